@@ hw/rtl/bpir_pkg.sv @@
// Shared types and constants of the bi-phase IR frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package bpir_pkg;

	localparam int DUR_W       = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_ADDR_W  = 3;
	localparam int BITS_W      = 32;
	localparam int COUNT_W     = 6;
	localparam int HEADER_BITS = 10;
	localparam int ADDR_W      = 9;
	localparam int DATA_W      = 22;
	localparam int NBITS_W     = 5;

	// Configuration register indexes.
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_SHORT_MIN_A = 3'd0,
		REG_SHORT_MAX_A = 3'd1,
		REG_LONG_MIN_A  = 3'd2,
		REG_LONG_MAX_A  = 3'd3,
		REG_SHORT_MIN_B = 3'd4,
		REG_SHORT_MAX_B = 3'd5,
		REG_LONG_MIN_B  = 3'd6,
		REG_LONG_MAX_B  = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_LEN  = 3'd1,
		ST_NO_EDGE  = 3'd2,
		ST_FEW      = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	// One set of pulse-length windows, bounds inclusive.
	typedef struct packed {
		logic [DUR_W-1:0] short_lo;
		logic [DUR_W-1:0] short_hi;
		logic [DUR_W-1:0] long_lo;
		logic [DUR_W-1:0] long_hi;
	} window_t;

	// Decoder state; pend[1] means a half-bit is held, pend[0] is its level.
	typedef struct packed {
		logic [BITS_W-1:0]  bits;
		logic [COUNT_W-1:0] count;
		logic [1:0]         pend;
		status_t            err;
	} dec_state_t;

	// Result item, status in the lowest bits.
	typedef struct packed {
		logic [DATA_W-1:0]  data_word;
		logic [ADDR_W-1:0]  address_word;
		logic [NBITS_W-1:0] bit_count;
		logic               used_secondary;
		status_t            status;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/bpir_dec.sv @@
// One bi-phase decoder lane: pulse to half-bits, half-bit pairs to data bits.
`timescale 1ns / 1ps
`default_nettype none

module bpir_dec #(
	parameter int MAX_HALF_BITS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic                        start,
	input  wire logic                        last,
	input  wire logic [bpir_pkg::DUR_W-1:0]  duration,
	input  wire logic                        level,
	input  wire bpir_pkg::window_t           win,
	output bpir_pkg::dec_state_t             res
);

	bpir_pkg::dec_state_t state_q;
	bpir_pkg::dec_state_t base;
	bpir_pkg::dec_state_t fed;
	bpir_pkg::dec_state_t fin;

	function automatic logic is_final(bpir_pkg::status_t e);
		return (e == bpir_pkg::ST_BAD_LEN) || (e == bpir_pkg::ST_OVERFLOW);
	endfunction

	function automatic bpir_pkg::dec_state_t push_half(bpir_pkg::dec_state_t s, logic lvl);
		logic [bpir_pkg::COUNT_W:0] total;
		bpir_pkg::dec_state_t r;
		r = s;
		total = {s.count, s.pend[1]};
		if (!is_final(s.err)) begin
			if (total >= (bpir_pkg::COUNT_W+1)'(MAX_HALF_BITS)) begin
				r.err = bpir_pkg::ST_OVERFLOW;
			end else if (s.pend[1]) begin
				if (s.pend[0] == lvl) begin
					if (s.err == bpir_pkg::ST_OK) r.err = bpir_pkg::ST_NO_EDGE;
				end else if (s.err == bpir_pkg::ST_OK) begin
					r.bits = {s.bits[bpir_pkg::BITS_W-2:0], s.pend[0]};
				end
				r.count = s.count + bpir_pkg::COUNT_W'(1);
				r.pend  = 2'b00;
			end else begin
				r.pend = {1'b1, lvl};
			end
		end
		return r;
	endfunction

	function automatic bpir_pkg::dec_state_t feed(bpir_pkg::dec_state_t s,
			logic [bpir_pkg::DUR_W-1:0] d, logic lvl, bpir_pkg::window_t w);
		bpir_pkg::dec_state_t r;
		r = s;
		if (!is_final(s.err)) begin
			if (d >= w.short_lo && d <= w.short_hi) begin
				r = push_half(s, lvl);
			end else if (d >= w.long_lo && d <= w.long_hi) begin
				r = push_half(push_half(s, lvl), lvl);
			end else begin
				r.err = bpir_pkg::ST_BAD_LEN;
			end
		end
		return r;
	endfunction

	always_comb begin
		base = start ? '0 : state_q;
		fed  = feed(base, duration, level, win);
		fin  = fed;
		// An odd final mark is closed with a space.
		if (fin.pend[1]) fin = push_half(fin, 1'b0);
		if (fin.err == bpir_pkg::ST_OK &&
		    fin.count < bpir_pkg::COUNT_W'(bpir_pkg::HEADER_BITS)) begin
			fin.err = bpir_pkg::ST_FEW;
		end
		res = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			state_q <= last ? '0 : fed;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bpir_fmt.sv @@
// Picks the decoder that supplies the result and splits its bits into fields.
`timescale 1ns / 1ps
`default_nettype none

module bpir_fmt (
	input  wire bpir_pkg::dec_state_t res_a,
	input  wire bpir_pkg::dec_state_t res_b,
	output bpir_pkg::result_t         result
);

	bpir_pkg::dec_state_t        sel;
	logic                        sec;
	logic [bpir_pkg::COUNT_W-1:0] nbits_w;
	logic [bpir_pkg::NBITS_W-1:0] nbits;
	logic [bpir_pkg::BITS_W-1:0]  shifted;
	logic [bpir_pkg::BITS_W-1:0]  mask;
	logic [bpir_pkg::BITS_W-1:0]  masked;

	always_comb begin
		sec = (res_a.err != bpir_pkg::ST_OK);
		sel = sec ? res_b : res_a;
		// A successful decode has at least the header bits and at most 32 bits.
		nbits_w = sel.count - bpir_pkg::COUNT_W'(bpir_pkg::HEADER_BITS);
		nbits   = nbits_w[bpir_pkg::NBITS_W-1:0];
		shifted = sel.bits >> nbits;
		mask    = (bpir_pkg::BITS_W'(1) << nbits) - bpir_pkg::BITS_W'(1);
		masked  = sel.bits & mask;

		result = '0;
		result.used_secondary = sec;
		result.status         = sel.err;
		if (sel.err == bpir_pkg::ST_OK) begin
			result.bit_count    = nbits;
			result.address_word = shifted[bpir_pkg::ADDR_W-1:0];
			result.data_word    = masked[bpir_pkg::DATA_W-1:0];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/biphase_ir_frame_decoder.sv @@
// Top level of the bi-phase IR frame decoder.
// Usage: each input item on the s_ channel is one measured pulse. s_tdata holds
// its duration in ticks, s_tuser flags the first pulse of a frame (a mark) and
// s_tlast flags the last pulse of the frame. Marks and spaces alternate.
// Two decoder lanes, one with the primary and one with the secondary window
// set, run side by side on every pulse. The item with s_tlast produces exactly
// one result item on the m_ channel; all other items produce none.
// Timing: an item is taken into the input register and decoded by both lanes
// in the following cycle; a frame end loads the output register when it leaves
// the input register, and m_tvalid rises with that load.
// Throughput: one item per cycle but for the stall below; the decoder state and
// mark/space level updates are the only loops, and the output register lets
// pulses keep flowing while a result waits. A frame-end item waits in the input
// register while an earlier result is held by a stalled receiver; s_tready drops.
// Reset clears the lanes, the item and result valid flags, and loads the
// default timing windows. The cfg_ port writes one window bound per cycle and
// is meant to be used only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module biphase_ir_frame_decoder #(
	parameter int MAX_HALF_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [15:0] cfg_wdata,
	// Pulse items.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [15:0] duration
	input  wire logic        s_tuser,  // [0] frame_start
	input  wire logic        s_tlast,  // frame_end
	// Result items.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [2:0] status, [3] used_secondary, [8:4] bit_count, [17:9] address_word,
	// [39:18] data_word
	output logic [39:0]      m_tdata
);

	bpir_pkg::window_t win_a_q;
	bpir_pkg::window_t win_b_q;

	logic                       valid_s1;
	logic [bpir_pkg::DUR_W-1:0] dur_s1;
	logic                       start_s1;
	logic                       last_s1;
	logic                       next_is_mark_q;
	logic                       level;
	logic                       adv;

	bpir_pkg::dec_state_t res_a;
	bpir_pkg::dec_state_t res_b;
	bpir_pkg::result_t    result;
	bpir_pkg::result_t    result_q;
	logic                 out_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_a_q <= '{short_lo: 16'd4, short_hi: 16'd10,
				long_lo: 16'd11, long_hi: 16'd16};
			win_b_q <= '{short_lo: 16'd2, short_hi: 16'd6,
				long_lo: 16'd7, long_hi: 16'd11};
		end else if (cfg_we) begin
			unique case (bpir_pkg::reg_idx_t'(cfg_addr))
				bpir_pkg::REG_SHORT_MIN_A: win_a_q.short_lo <= cfg_wdata;
				bpir_pkg::REG_SHORT_MAX_A: win_a_q.short_hi <= cfg_wdata;
				bpir_pkg::REG_LONG_MIN_A:  win_a_q.long_lo  <= cfg_wdata;
				bpir_pkg::REG_LONG_MAX_A:  win_a_q.long_hi  <= cfg_wdata;
				bpir_pkg::REG_SHORT_MIN_B: win_b_q.short_lo <= cfg_wdata;
				bpir_pkg::REG_SHORT_MAX_B: win_b_q.short_hi <= cfg_wdata;
				bpir_pkg::REG_LONG_MIN_B:  win_b_q.long_lo  <= cfg_wdata;
				bpir_pkg::REG_LONG_MAX_B:  win_b_q.long_hi  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The item in the input register moves on unless it ends a frame and the
	// result register is still held by the receiver.
	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			dur_s1   <= s_tdata;
			start_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	// A frame start forces a mark; after each pulse the level flips, and a
	// frame end makes the next pulse a mark again.
	assign level = start_s1 ? 1'b1 : next_is_mark_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_is_mark_q <= 1'b1;
		end else if (adv) begin
			next_is_mark_q <= last_s1 ? 1'b1 : ~level;
		end
	end

	bpir_dec #(.MAX_HALF_BITS(MAX_HALF_BITS)) u_dec_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.start    (start_s1),
		.last     (last_s1),
		.duration (dur_s1),
		.level    (level),
		.win      (win_a_q),
		.res      (res_a)
	);

	bpir_dec #(.MAX_HALF_BITS(MAX_HALF_BITS)) u_dec_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.start    (start_s1),
		.last     (last_s1),
		.duration (dur_s1),
		.level    (level),
		.win      (win_b_q),
		.res      (res_b)
	);

	bpir_fmt u_fmt (
		.res_a  (res_a),
		.res_b  (res_b),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;

	// A frame end that leaves the input register always yields a result.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> out_valid_q)
		else $error("frame end produced no result");

	// A new result only appears after a frame end was decoded.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && last_s1))
		else $error("result appeared without a frame end");

	// The pulse after a frame end is taken as a mark.
	a_mark_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> next_is_mark_q)
		else $error("level not returned to mark after frame end");

	// A primary-lane result is always a successful decode.
	a_primary_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.used_secondary |-> result_q.status == bpir_pkg::ST_OK)
		else $error("primary result with error status");

endmodule

`default_nettype wire
